@@ rtl/hvns_pkg.sv @@
// shared types and constants of the heightmap vertex-normal shader
// no dependencies
package hvns_pkg;

  localparam int HEIGHT_W = 24;
  localparam int VEC_W    = 26;
  localparam int NRM_W    = 16;
  localparam int ACC_W    = 19;
  localparam int DIM_W    = 13;
  localparam int NUM_TAPS = 7;
  localparam int NUM_FACE = 6;
  localparam logic signed [14:0] LIGHT_Q14 = 15'sd9459;
  localparam logic signed [NRM_W-1:0] ONE_Q14 = 16'sd16384;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [1:0] REG_NUM_ROWS = 2'd0;
  localparam logic [1:0] REG_NUM_COLS = 2'd1;
  localparam logic [1:0] REG_SPACING  = 2'd2;
  localparam logic [1:0] REG_GAIN     = 2'd3;

  // height taps around the vertex
  localparam logic [2:0] TAP_C  = 3'd0;
  localparam logic [2:0] TAP_E  = 3'd1;
  localparam logic [2:0] TAP_S  = 3'd2;
  localparam logic [2:0] TAP_W  = 3'd3;
  localparam logic [2:0] TAP_SW = 3'd4;
  localparam logic [2:0] TAP_N  = 3'd5;
  localparam logic [2:0] TAP_NE = 3'd6;

  typedef enum logic [3:0] {
    S_IDLE, S_FETCH, S_FACE, S_WAIT, S_NORM, S_NWAIT, S_SHADE, S_FINAL
  } seq_state_t;

  typedef enum logic [2:0] {
    U_IDLE, U_SCALE, U_SQUARE, U_ROOT, U_LOAD, U_DIVIDE, U_DONE
  } unit_state_t;

  typedef struct packed {
    logic                    start;
    logic signed [VEC_W-1:0] vx;
    logic signed [VEC_W-1:0] vy;
    logic signed [VEC_W-1:0] vz;
  } unit_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [NRM_W-1:0] nx;
    logic signed [NRM_W-1:0] ny;
    logic signed [NRM_W-1:0] nz;
  } unit_rsp_t;

endpackage

@@ rtl/hvns_if.sv @@
// valid/ready channels of the shader: query/write items in, results out
// depends on nothing
interface hvns_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] row;
  logic [7:0] col;
  logic [7:0] height_sample;
  modport source (output valid, opcode, row, col, height_sample, input ready);
  modport sink (input valid, opcode, row, col, height_sample, output ready);
endinterface

interface hvns_out_if;
  logic               valid;
  logic               ready;
  logic               status;
  logic        [23:0] scaled_height;
  logic signed [15:0] normal_x;
  logic signed [15:0] normal_y;
  logic signed [15:0] normal_z;
  logic signed [15:0] shade;
  modport source (output valid, status, scaled_height, normal_x, normal_y, normal_z, shade,
                  input ready);
  modport sink (input valid, status, scaled_height, normal_x, normal_y, normal_z, shade,
                output ready);
endinterface

@@ rtl/hvns_unit.sv @@
// vector normalizer: scale up, sum of squares, bit-serial root, bit-serial divides
// depends on hvns_pkg
module hvns_unit
  import hvns_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  unit_req_t ureq,
  output unit_rsp_t ursp
);

  unit_state_t state, state_next;

  logic signed [VEC_W-1:0] wv [3];
  logic signed [NRM_W-1:0] nv [3];
  logic [1:0]  idx;
  logic [51:0] s;
  logic [51:0] rem;
  logic [51:0] res;
  logic [4:0]  k;
  logic [40:0] num;
  logic [14:0] q;
  logic [3:0]  dcnt;

  logic [VEC_W-1:0] mag [3];
  logic             short_vec, zero_in;
  logic signed [2*VEC_W-1:0] sq;
  logic [51:0] bitv, trial;
  logic [25:0] len;
  logic [40:0] dvs;
  logic        ge;
  logic [14:0] q_next;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = wv[i][VEC_W-1] ? VEC_W'(-wv[i]) : VEC_W'(wv[i]);
    end
    short_vec = (mag[0] < VEC_W'(1 << 20)) && (mag[1] < VEC_W'(1 << 20)) &&
                (mag[2] < VEC_W'(1 << 20));
    zero_in = (ureq.vx == '0) && (ureq.vy == '0) && (ureq.vz == '0);
    sq = wv[idx] * wv[idx];
    bitv = 52'(1) << {k, 1'b0};
    trial = res + bitv;
    len = res[25:0];
    dvs = 41'(len) << dcnt;
    ge = (num >= dvs);
    q_next = ge ? (q | (15'(1) << dcnt)) : q;
  end

  always_comb begin
    state_next = state;
    case (state)
      U_IDLE:   if (ureq.start) state_next = zero_in ? U_DONE : U_SCALE;
      U_SCALE:  if (!short_vec) state_next = U_SQUARE;
      U_SQUARE: if (idx == 2'd2) state_next = U_ROOT;
      U_ROOT:   if (k == '0) state_next = U_LOAD;
      U_LOAD:   state_next = U_DIVIDE;
      U_DIVIDE: if (dcnt == '0) state_next = (idx == 2'd2) ? U_DONE : U_LOAD;
      U_DONE:   state_next = U_IDLE;
      default:  state_next = U_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= U_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    case (state)
      U_IDLE: begin
        wv[0] <= ureq.vx;
        wv[1] <= ureq.vy;
        wv[2] <= ureq.vz;
        s <= '0;
        idx <= '0;
        for (int i = 0; i < 3; i++) nv[i] <= '0;
      end
      U_SCALE: begin
        if (short_vec) begin
          for (int i = 0; i < 3; i++) wv[i] <= wv[i] <<< 1;
        end
      end
      U_SQUARE: begin
        s <= s + 52'(unsigned'(sq));
        idx <= (idx == 2'd2) ? 2'd0 : idx + 2'd1;
        rem <= s + 52'(unsigned'(sq));
        res <= '0;
        k <= 5'd25;
      end
      U_ROOT: begin
        if (rem >= trial) begin
          rem <= rem - trial;
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        k <= k - 5'd1;
      end
      U_LOAD: begin
        num <= (41'(mag[idx]) << 14) + 41'(len >> 1);
        q <= '0;
        dcnt <= 4'd14;
      end
      U_DIVIDE: begin
        if (ge) num <= num - dvs;
        q <= q_next;
        dcnt <= dcnt - 4'd1;
        if (dcnt == '0) begin
          nv[idx] <= wv[idx][VEC_W-1] ? -NRM_W'(q_next) : NRM_W'(q_next);
          idx <= idx + 2'd1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    ursp.done = (state == U_DONE);
    ursp.nx = nv[0];
    ursp.ny = nv[1];
    ursp.nz = nv[2];
  end

endmodule

@@ rtl/heightmap_vertex_normal_shader.sv @@
// top level of the heightmap vertex-normal shader: height memory and query sequencer
// depends on hvns_pkg, hvns_if and hvns_unit
//
// Write items store one height byte each; they are taken while a result waits at the
// output. A query reads seven heights around the vertex from the height memory, then
// runs each adjacent face vector present (up to six) and finally the normal sum through
// one shared normalizer. A normalization doubles short vectors, then forms the sum of
// squares, a bit-serial square root and three bit-serial divides. Queries outside the
// grid skip the fetch and return status 1. The height memory has no reset; a query
// must only touch written samples.
module heightmap_vertex_normal_shader
  import hvns_pkg::*;
#(
  parameter int MAX_ROWS = 256,
  parameter int MAX_COLS = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  hvns_in_if.sink     req,
  hvns_out_if.source  rsp
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);

  // configuration registers
  logic [8:0]  num_rows, num_cols;
  logic [15:0] cell_spacing, height_gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_rows <= 9'd2;
      num_cols <= 9'd2;
      cell_spacing <= 16'd256;
      height_gain <= 16'd256;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NUM_ROWS: num_rows <= cfg_data[8:0];
        REG_NUM_COLS: num_cols <= cfg_data[8:0];
        REG_SPACING:  cell_spacing <= cfg_data;
        REG_GAIN:     height_gain <= cfg_data;
        default: ;
      endcase
    end
  end

  // grid size clamped to [2, MAX]
  logic [DIM_W-1:0] rows, cols;
  always_comb begin
    rows = (num_rows < 9'd2) ? DIM_W'(2) :
           (DIM_W'(num_rows) > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : DIM_W'(num_rows);
    cols = (num_cols < 9'd2) ? DIM_W'(2) :
           (DIM_W'(num_cols) > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : DIM_W'(num_cols);
  end

  seq_state_t state, state_next;

  logic [7:0] qrow, qcol;
  logic [2:0] fk;
  logic [2:0] face;
  logic [HEIGHT_W-1:0] h [NUM_TAPS];
  logic signed [ACC_W-1:0] acc [3];
  logic signed [NRM_W-1:0] nrm [3];
  logic signed [32:0] shade_prod;
  logic out_of_grid;

  // result waiting for the output register
  logic               res_status;
  logic        [23:0] res_height;

  logic               out_valid;
  logic               out_status;
  logic        [23:0] out_height;
  logic signed [15:0] out_nx, out_ny, out_nz, out_shade;

  unit_req_t ureq;
  unit_rsp_t ursp;

  hvns_unit u_unit (
    .clk  (clk),
    .rst  (rst),
    .ureq (ureq),
    .ursp (ursp)
  );

  // neighborhood of the query vertex
  logic down, up, left, right;
  always_comb begin
    down  = (DIM_W'(qrow) + DIM_W'(1)) < rows;
    right = (DIM_W'(qcol) + DIM_W'(1)) < cols;
    up    = (qrow != 8'd0);
    left  = (qcol != 8'd0);
  end

  logic face_en;
  always_comb begin
    case (face)
      3'd0:    face_en = down && right;
      3'd1:    face_en = down && left;
      3'd2:    face_en = down && left;
      3'd3:    face_en = up && right;
      3'd4:    face_en = up && right;
      3'd5:    face_en = up && left;
      default: face_en = 1'b0;
    endcase
  end

  // face vector: x and z from height differences, y is the spacing
  logic [2:0] xa, xb, za, zb;
  always_comb begin
    case (face)
      3'd0:    begin xa = TAP_C;  xb = TAP_E;  za = TAP_S; zb = TAP_C;  end
      3'd1:    begin xa = TAP_W;  xb = TAP_C;  za = TAP_SW; zb = TAP_W; end
      3'd2:    begin xa = TAP_SW; xb = TAP_S;  za = TAP_S; zb = TAP_C;  end
      3'd3:    begin xa = TAP_N;  xb = TAP_NE; za = TAP_C; zb = TAP_N;  end
      3'd4:    begin xa = TAP_C;  xb = TAP_E;  za = TAP_E; zb = TAP_NE; end
      default: begin xa = TAP_W;  xb = TAP_C;  za = TAP_C; zb = TAP_N;  end
    endcase
  end

  logic signed [VEC_W-1:0] fvx, fvz;
  always_comb begin
    fvx = signed'(VEC_W'(h[xa])) - signed'(VEC_W'(h[xb]));
    fvz = signed'(VEC_W'(h[za])) - signed'(VEC_W'(h[zb]));
  end

  // fetch addresses: tap fk at (row+dr, col+dc), wrapped like the store
  logic [31:0] fr, fc, faddr;
  always_comb begin
    fr = 32'(qrow);
    fc = 32'(qcol);
    case (fk)
      TAP_E:   fc = 32'(qcol) + 32'd1;
      TAP_S:   fr = 32'(qrow) + 32'd1;
      TAP_W:   fc = 32'(qcol) - 32'd1;
      TAP_SW:  begin fr = 32'(qrow) + 32'd1; fc = 32'(qcol) - 32'd1; end
      TAP_N:   fr = 32'(qrow) - 32'd1;
      TAP_NE:  begin fr = 32'(qrow) - 32'd1; fc = 32'(qcol) + 32'd1; end
      default: ;
    endcase
    faddr = fr * 32'(MAX_COLS) + fc;
  end

  // height memory: one write and one read per cycle, registered read data
  logic [7:0]    hmem [DEPTH];
  logic [7:0]    hdout;
  logic          in_xfer, mem_we;
  logic [AW-1:0] waddr;

  always_comb begin
    in_xfer = req.valid && req.ready;
    mem_we = in_xfer && (req.opcode == OP_WRITE) &&
             (32'(req.row) < 32'(MAX_ROWS)) && (32'(req.col) < 32'(MAX_COLS));
    waddr = AW'(32'(req.row) * 32'(MAX_COLS) + 32'(req.col));
  end

  always_ff @(posedge clk) begin
    if (mem_we) hmem[waddr] <= req.height_sample;
    hdout <= hmem[faddr[AW-1:0]];
  end

  // sequencer
  logic out_free;
  assign out_free = !out_valid || rsp.ready;
  assign req.ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_xfer && req.opcode == OP_QUERY) begin
          state_next = ((DIM_W'(req.row) >= rows) || (DIM_W'(req.col) >= cols)) ?
                       S_FINAL : S_FETCH;
        end
      end
      S_FETCH:  if (fk == 3'(NUM_TAPS)) state_next = S_FACE;
      S_FACE: begin
        if (face_en) state_next = S_WAIT;
        else if (face == 3'(NUM_FACE - 1)) state_next = S_NORM;
      end
      S_WAIT: begin
        if (ursp.done) state_next = (face == 3'(NUM_FACE - 1)) ? S_NORM : S_FACE;
      end
      S_NORM:   state_next = S_NWAIT;
      S_NWAIT:  if (ursp.done) state_next = S_SHADE;
      S_SHADE:  state_next = S_FINAL;
      S_FINAL:  if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ureq.start = 1'b0;
    ureq.vx = fvx;
    ureq.vy = signed'(VEC_W'(cell_spacing));
    ureq.vz = fvz;
    if (state == S_FACE) begin
      ureq.start = face_en;
    end else if (state == S_NORM) begin
      ureq.start = 1'b1;
      ureq.vx = VEC_W'(acc[0]);
      ureq.vy = VEC_W'(acc[1]);
      ureq.vz = VEC_W'(acc[2]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        qrow <= req.row;
        qcol <= req.col;
        fk <= '0;
        face <= '0;
        out_of_grid <= 1'b1;
        for (int i = 0; i < 3; i++) begin
          acc[i] <= '0;
          nrm[i] <= '0;
        end
        shade_prod <= '0;
      end
      S_FETCH: begin
        // tap fk-1 lands in hdout while tap fk is addressed
        if (fk != '0) h[fk - 3'd1] <= HEIGHT_W'(hdout) * HEIGHT_W'(height_gain);
        fk <= fk + 3'd1;
        out_of_grid <= 1'b0;
      end
      S_FACE: begin
        if (!face_en && face != 3'(NUM_FACE - 1)) face <= face + 3'd1;
      end
      S_WAIT: begin
        if (ursp.done) begin
          acc[0] <= acc[0] + ACC_W'(ursp.nx);
          acc[1] <= acc[1] + ACC_W'(ursp.ny);
          acc[2] <= acc[2] + ACC_W'(ursp.nz);
          if (face != 3'(NUM_FACE - 1)) face <= face + 3'd1;
        end
      end
      S_NWAIT: begin
        if (ursp.done) begin
          nrm[0] <= ursp.nx;
          nrm[1] <= ursp.ny;
          nrm[2] <= ursp.nz;
        end
      end
      S_SHADE: begin
        shade_prod <= (33'(nrm[0]) + 33'(nrm[1]) + 33'(nrm[2])) * 33'(LIGHT_Q14);
      end
      default: ;
    endcase
  end

  // rounded and clamped shade
  logic signed [32:0] shade_rnd;
  logic signed [15:0] shade_val;
  always_comb begin
    shade_rnd = (shade_prod + 33'sd8192) >>> 14;
    if (shade_rnd > 33'(ONE_Q14)) shade_val = ONE_Q14;
    else if (shade_rnd < -33'(ONE_Q14)) shade_val = -ONE_Q14;
    else shade_val = 16'(shade_rnd);
    res_status = out_of_grid;
    res_height = out_of_grid ? 24'd0 : h[TAP_C];
  end

  // output register: holds one result while the next item comes in
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_FINAL && out_free) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FINAL && out_free) begin
      out_status <= res_status;
      out_height <= res_height;
      out_nx <= nrm[0];
      out_ny <= nrm[1];
      out_nz <= nrm[2];
      out_shade <= out_of_grid ? 16'sd0 : shade_val;
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.status = out_status;
  assign rsp.scaled_height = out_height;
  assign rsp.normal_x = out_nx;
  assign rsp.normal_y = out_ny;
  assign rsp.normal_z = out_nz;
  assign rsp.shade = out_shade;

  // a query always leaves the idle state
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    in_xfer && req.opcode == OP_QUERY |=> state != S_IDLE)
    else $error("query transfer did not start the sequencer");

  // normalizer finishes with a single pulse
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    ursp.done |=> !ursp.done)
    else $error("normalizer done longer than one cycle");

  // face result moves the sequencer on
  a_face_step: assert property (@(posedge clk) disable iff (rst)
    state == S_WAIT && ursp.done |=> state == S_FACE || state == S_NORM)
    else $error("sequencer missed a face result");

  // normalizer is only started from the face or final normal states
  a_start_src: assert property (@(posedge clk) disable iff (rst)
    ureq.start |-> state == S_FACE || state == S_NORM)
    else $error("normalizer started outside a face step");

endmodule

@@ bench/tb.sv @@
// self-checking bench for heightmap_vertex_normal_shader: height writes, vertex queries
// depends on hvns_pkg, hvns_if and the shader rtl
module tb;
  import hvns_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef longint trio_t [3];

  typedef struct {
    logic       opcode;
    logic [7:0] row;
    logic [7:0] col;
    logic [7:0] height_sample;
  } item_t;

  typedef struct {
    logic               status;
    logic        [23:0] scaled_height;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic signed [15:0] shade;
  } shading_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  hvns_in_if  req ();
  hvns_out_if rsp ();

  heightmap_vertex_normal_shader DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req.sink),
    .rsp       (rsp.source)
  );

  // bench copy of the block state
  logic [7:0]  heights [0:65535];
  logic [8:0]  grid_rows, grid_cols;
  logic [15:0] spacing, gain;

  item_t    pending_items[$];
  shading_t expected_shading[$];
  int       errors;
  int       items_sent;
  bit       calm;        // phase with no idling on either side
  int       send_gap;
  int       stall_left;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 120);
  endfunction

  function automatic int grid_dim(logic [8:0] v);
    if (v < 2) return 2;
    if (v > 256) return 256;
    return v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // scale up until the largest component reaches 2^20, then round to q1.14
  function automatic trio_t unit_vec(trio_t v);
    trio_t w, n;
    longint m, a;
    longint unsigned sq, len, q;
    m = 0;
    sq = 0;
    for (int i = 0; i < 3; i++) begin
      w[i] = v[i];
      a = (w[i] < 0) ? -w[i] : w[i];
      if (a > m) m = a;
    end
    if (m == 0) begin
      n[0] = 0; n[1] = 0; n[2] = 0;
      return n;
    end
    while (m < (64'sd1 << 20)) begin
      for (int i = 0; i < 3; i++) w[i] = w[i] * 2;
      m = m * 2;
    end
    for (int i = 0; i < 3; i++) sq = sq + longint'(w[i] * w[i]);
    len = int_sqrt(sq);
    for (int i = 0; i < 3; i++) begin
      a = (w[i] < 0) ? -w[i] : w[i];
      q = (longint'(a) * 16384 + len / 2) / len;
      n[i] = (w[i] < 0) ? -longint'(q) : longint'(q);
    end
    return n;
  endfunction

  function automatic longint height_at(int r, int c);
    return longint'(heights[{r[7:0], c[7:0]}]) * longint'(gain);
  endfunction

  function automatic void add_face(ref trio_t acc, input longint x, input longint z);
    trio_t v, n;
    v[0] = x;
    v[1] = longint'(spacing);
    v[2] = z;
    n = unit_vec(v);
    for (int i = 0; i < 3; i++) acc[i] += n[i];
  endfunction

  // triangle (a, a+1, b) of cell r,c
  function automatic void upper_face(ref trio_t acc, input int r, input int c);
    longint h00;
    h00 = height_at(r, c);
    add_face(acc, -(height_at(r, c + 1) - h00), height_at(r + 1, c) - h00);
  endfunction

  // triangle (b, a+1, b+1) of cell r,c
  function automatic void lower_face(ref trio_t acc, input int r, input int c);
    longint h11;
    h11 = height_at(r + 1, c + 1);
    add_face(acc, -(h11 - height_at(r + 1, c)), h11 - height_at(r, c + 1));
  endfunction

  function automatic shading_t shade_vertex(int r, int c);
    shading_t s;
    trio_t acc, n;
    int rows, cols;
    longint t, sh;
    rows = grid_dim(grid_rows);
    cols = grid_dim(grid_cols);
    s = '{default: '0};
    if (r >= rows || c >= cols) begin
      s.status = 1'b1;
      return s;
    end
    acc[0] = 0; acc[1] = 0; acc[2] = 0;
    if (r + 1 < rows && c + 1 < cols) upper_face(acc, r, c);
    if (r + 1 < rows && c >= 1) begin
      upper_face(acc, r, c - 1);
      lower_face(acc, r, c - 1);
    end
    if (r >= 1 && c + 1 < cols) begin
      upper_face(acc, r - 1, c);
      lower_face(acc, r - 1, c);
    end
    if (r >= 1 && c >= 1) lower_face(acc, r - 1, c - 1);
    n = unit_vec(acc);
    // lambert term against (1,1,1)/sqrt3, rounded half up then clamped
    t = (n[0] + n[1] + n[2]) * longint'(LIGHT_Q14);
    sh = (t + 8192) >>> 14;
    if (sh > 16384) sh = 16384;
    if (sh < -16384) sh = -16384;
    s.status        = 1'b0;
    s.scaled_height = 24'(height_at(r, c));
    s.normal_x      = 16'(n[0]);
    s.normal_y      = 16'(n[1]);
    s.normal_z      = 16'(n[2]);
    s.shade         = 16'(sh);
    return s;
  endfunction

  // sender: pops pending items, random gaps between transfers
  always @(posedge clk) begin
    item_t it;
    if (rst) begin
      req.valid <= 1'b0;
      send_gap = 0;
    end else if (!req.valid || req.ready) begin
      if (send_gap > 0) begin
        send_gap--;
        req.valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        it = pending_items.pop_front();
        req.opcode        <= it.opcode;
        req.row           <= it.row;
        req.col           <= it.col;
        req.height_sample <= it.height_sample;
        req.valid         <= 1'b1;
        send_gap = pick_gap();
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls after each result transfer
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
      stall_left = 0;
    end else if (rsp.valid && rsp.ready) begin
      stall_left = pick_gap();
      rsp.ready <= (stall_left == 0);
    end else if (stall_left > 0) begin
      stall_left--;
      rsp.ready <= (stall_left == 0);
    end else begin
      rsp.ready <= 1'b1;
    end
  end

  // monitor: predict on each input transfer, check each result transfer
  always @(posedge clk) begin
    shading_t want;
    if (!rst) begin
      if (req.valid && req.ready) begin
        if (req.opcode == OP_WRITE)
          heights[{req.row, req.col}] = req.height_sample;
        else
          expected_shading.push_back(shade_vertex(req.row, req.col));
      end
      if (rsp.valid && rsp.ready) begin
        if (expected_shading.size() == 0) begin
          $display("%0t: result with nothing expected: status %0d height %0d", $realtime,
                   rsp.status, rsp.scaled_height);
          errors++;
        end else begin
          want = expected_shading.pop_front();
          if (rsp.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $realtime, want.status,
                     rsp.status);
            errors++;
          end
          if (rsp.scaled_height !== want.scaled_height) begin
            $display("%0t: scaled_height expected %0d actual %0d", $realtime,
                     want.scaled_height, rsp.scaled_height);
            errors++;
          end
          if (rsp.normal_x !== want.normal_x) begin
            $display("%0t: normal_x expected %0d actual %0d", $realtime, want.normal_x,
                     rsp.normal_x);
            errors++;
          end
          if (rsp.normal_y !== want.normal_y) begin
            $display("%0t: normal_y expected %0d actual %0d", $realtime, want.normal_y,
                     rsp.normal_y);
            errors++;
          end
          if (rsp.normal_z !== want.normal_z) begin
            $display("%0t: normal_z expected %0d actual %0d", $realtime, want.normal_z,
                     rsp.normal_z);
            errors++;
          end
          if (rsp.shade !== want.shade) begin
            $display("%0t: shade expected %0d actual %0d", $realtime, want.shade,
                     rsp.shade);
            errors++;
          end
        end
      end
    end
  end

  task automatic push_item(logic op, int r, int c, int h);
    item_t it;
    it.opcode        = op;
    it.row           = r[7:0];
    it.col           = c[7:0];
    it.height_sample = h[7:0];
    pending_items.push_back(it);
    items_sent++;
  endtask

  // waits until every item is sent and every result is in, plus slack for a trailing write
  task automatic drain();
    do begin
      @(posedge clk);
      #1;
    end while (pending_items.size() != 0 || req.valid || expected_shading.size() != 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_NUM_ROWS: grid_rows = val[8:0];
      REG_NUM_COLS: grid_cols = val[8:0];
      REG_SPACING:  spacing   = val;
      REG_GAIN:     gain      = val;
      default: ;
    endcase
  endtask

  // one setting: program all registers, fill the grid, then a random mix
  task automatic run_phase(int rows_v, int cols_v, int sp, int gn, int n_rand,
                           bit flat, int flat_h);
    int rows, cols, r, c, pick;
    drain();
    write_reg(REG_NUM_ROWS, rows_v[15:0]);
    write_reg(REG_NUM_COLS, cols_v[15:0]);
    write_reg(REG_SPACING, sp[15:0]);
    write_reg(REG_GAIN, gn[15:0]);
    @(posedge clk);
    cfg_we <= 1'b0;
    calm = ($urandom_range(0, 3) == 0);
    rows = grid_dim(grid_rows);
    cols = grid_dim(grid_cols);
    for (r = 0; r < rows; r++)
      for (c = 0; c < cols; c++)
        push_item(OP_WRITE, r, c, flat ? flat_h : $urandom_range(0, 255));
    for (int k = 0; k < n_rand; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45 && !flat) begin
        // writes land anywhere in the store, inside the grid or not
        r = $urandom_range(0, 255);
        c = $urandom_range(0, 255);
        if (pick < 25) begin
          r = $urandom_range(0, rows - 1);
          c = $urandom_range(0, cols - 1);
        end
        push_item(OP_WRITE, r, c, $urandom_range(0, 255));
      end else if (pick < 52 && (rows < 256 || cols < 256)) begin
        // query off the grid
        if (rows < 256 && (cols == 256 || $urandom_range(0, 1)))
          push_item(OP_QUERY, $urandom_range(rows, 255), $urandom_range(0, 255), 0);
        else
          push_item(OP_QUERY, $urandom_range(0, 255), $urandom_range(cols, 255), 0);
      end else begin
        push_item(OP_QUERY, $urandom_range(0, rows - 1), $urandom_range(0, cols - 1),
                  $urandom_range(0, 255));
      end
    end
  endtask

  initial begin
    errors     = 0;
    items_sent = 0;
    calm       = 1'b0;
    grid_rows  = 9'd2;
    grid_cols  = 9'd2;
    spacing    = 16'd256;
    gain       = 16'd256;
    rst        = 1'b1;
    cfg_we     = 1'b0;
    cfg_index  = REG_NUM_ROWS;
    cfg_data   = '0;
    req.valid  = 1'b0;
    req.opcode = OP_WRITE;
    req.row    = '0;
    req.col    = '0;
    req.height_sample = '0;
    rsp.ready  = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: reset setting, 2x2 grid with steep corners
    push_item(OP_WRITE, 0, 0, 0);
    push_item(OP_WRITE, 0, 1, 255);
    push_item(OP_WRITE, 1, 0, 255);
    push_item(OP_WRITE, 1, 1, 0);
    push_item(OP_QUERY, 0, 0, 0);
    push_item(OP_QUERY, 0, 1, 0);
    push_item(OP_QUERY, 1, 0, 0);
    push_item(OP_QUERY, 1, 1, 255);
    // queries off the grid
    push_item(OP_QUERY, 2, 0, 0);
    push_item(OP_QUERY, 0, 2, 0);
    push_item(OP_QUERY, 255, 255, 0);
    // write outside the grid is kept, then overwrite a corner
    push_item(OP_WRITE, 255, 255, 8'hAA);
    push_item(OP_WRITE, 1, 1, 8'h55);
    push_item(OP_QUERY, 1, 1, 0);
    push_item(OP_QUERY, 0, 0, 0);

    // extremes of the registers
    run_phase(0, 1, 1, 65535, 20, 0, 0);        // sizes below 2 act as 2
    run_phase(3, 3, 0, 256, 8, 1, 77);          // zero spacing, flat: zero vectors
    run_phase(3, 4, 0, 256, 12, 0, 0);          // zero spacing, rough terrain
    run_phase(511, 2, 65535, 0, 30, 0, 0);      // rows clamp to 256, zero gain
    run_phase(2, 256, 1, 65535, 30, 0, 0);      // widest grid, tightest spacing
    run_phase(5, 6, 65535, 65535, 25, 0, 0);
    run_phase(4, 4, 256, 0, 12, 0, 0);

    // random settings, mostly small grids
    while (items_sent < 1350) begin
      run_phase($urandom_range(0, 9), $urandom_range(0, 9),
                ($urandom_range(0, 3) == 0) ? $urandom_range(1, 65535)
                                            : $urandom_range(16, 1024),
                ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                            : $urandom_range(1, 1024),
                70, 0, 0);
    end

    drain();
    repeat (50) @(posedge clk);
    if (errors == 0)
      $display("heightmap_vertex_normal_shader regression: pass");
    else
      $display("heightmap_vertex_normal_shader regression: fail");
    $finish;
  end

  // watchdog
  initial begin
    #200ms;
    $display("heightmap_vertex_normal_shader regression: fail");
    $finish;
  end

endmodule
